FILE: hdl/crss_pkg.sv
// Shared types, command codes and spline constants for the stroke smoother.
// No dependencies; imported by every module of the block.
package crss_pkg;

    // command codes carried in tuser of the input stream
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam int COORD_W = 16;
    localparam int SUBDIV  = 5;                 // vertices per spline segment
    localparam int IDX_W   = $clog2(SUBDIV + 1);

    localparam int QUEUE_DEPTH_DEF = 2;

    // 2*S^3 = 250; divide via reciprocal, exact for |num| + 125 < 2^27
    localparam int              RECIP_SHIFT = 36;
    localparam logic [28:0]     RECIP       = 29'(((64'd1 << RECIP_SHIFT) + 249) / 250);
    localparam logic [6:0]      DEN         = 7'd125;   // half of 2*S^3 for rounding

    // polynomial coefficients of one axis; a = p1, b = p2-p0,
    // c = 2p0-5p1+4p2-p3, d = -p0+3p1-3p2+p3
    typedef struct packed {
        logic signed [15:0] a;
        logic signed [16:0] b;
        logic signed [19:0] c;
        logic signed [19:0] d;
    } t_coef;

    typedef struct packed {
        t_coef cx;
        t_coef cy;
        logic  is_move;
        logic  single;      // one vertex (move or line), else SUBDIV spline vertices
    } t_job;

    // per-step weights: S^2*i, S*i^2, i^3
    function automatic logic [6:0] k_lin(input logic [IDX_W-1:0] i);
        logic [6:0] k;
        unique case (i)
            3'd1:    k = 7'd25;
            3'd2:    k = 7'd50;
            3'd3:    k = 7'd75;
            3'd4:    k = 7'd100;
            3'd5:    k = 7'd125;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] k_sq(input logic [IDX_W-1:0] i);
        logic [6:0] k;
        unique case (i)
            3'd1:    k = 7'd5;
            3'd2:    k = 7'd20;
            3'd3:    k = 7'd45;
            3'd4:    k = 7'd80;
            3'd5:    k = 7'd125;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

    function automatic logic [6:0] k_cub(input logic [IDX_W-1:0] i);
        logic [6:0] k;
        unique case (i)
            3'd1:    k = 7'd1;
            3'd2:    k = 7'd8;
            3'd3:    k = 7'd27;
            3'd4:    k = 7'd64;
            3'd5:    k = 7'd125;
            default: k = 7'd0;
        endcase
        return k;
    endfunction

endpackage

FILE: hdl/crss_front.sv
// Front end: takes input transactions, tracks stroke state and point history,
// and turns each command into a vertex job. Depends on crss_pkg.
module crss_front
    import crss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic [1:0]                i_cmd,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    output logic                      o_push,
    output t_job                      o_job
);

    logic                      r_open, n_open;
    logic [1:0]                r_seen, n_seen;
    logic signed [COORD_W-1:0] r_hx [3];
    logic signed [COORD_W-1:0] r_hy [3];
    logic                      w_shift;

    function automatic t_coef spline_coef(input logic signed [15:0] p0,
                                          input logic signed [15:0] p1,
                                          input logic signed [15:0] p2,
                                          input logic signed [15:0] p3);
        t_coef              cf;
        logic signed [19:0] e0, e1, e2, e3;
        e0 = 20'(p0);
        e1 = 20'(p1);
        e2 = 20'(p2);
        e3 = 20'(p3);
        cf.a = p1;
        cf.b = 17'(p2) - 17'(p0);
        cf.c = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        cf.d = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
        return cf;
    endfunction

    function automatic t_coef point_coef(input logic signed [15:0] p);
        t_coef cf;
        cf.a = p;
        cf.b = '0;
        cf.c = '0;
        cf.d = '0;
        return cf;
    endfunction

    always_comb begin
        n_open  = r_open;
        n_seen  = r_seen;
        w_shift = 1'b0;
        o_push  = 1'b0;
        o_job.cx      = point_coef(i_x);
        o_job.cy      = point_coef(i_y);
        o_job.is_move = 1'b0;
        o_job.single  = 1'b1;
        if (i_accept) begin
            unique case (i_cmd)
                CMD_START: begin
                    n_open        = 1'b1;
                    n_seen        = 2'd1;
                    w_shift       = 1'b1;
                    o_push        = 1'b1;
                    o_job.is_move = 1'b1;
                end
                CMD_ADD: begin
                    if (r_open) begin
                        w_shift = 1'b1;
                        o_push  = 1'b1;
                        if (r_seen == 2'd3) begin
                            o_job.cx     = spline_coef(r_hx[0], r_hx[1], r_hx[2], i_x);
                            o_job.cy     = spline_coef(r_hy[0], r_hy[1], r_hy[2], i_y);
                            o_job.single = 1'b0;
                        end else begin
                            n_seen = r_seen + 2'd1;
                        end
                    end
                end
                CMD_END: begin
                    n_open = 1'b0;
                    n_seen = 2'd0;
                end
                default: begin
                    // unused code: ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_seen <= 2'd0;
        end else begin
            r_open <= n_open;
            r_seen <= n_seen;
        end
    end

    // history feeds only spline jobs, which need three pushes of the open stroke
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_hx[0] <= r_hx[1];
            r_hx[1] <= r_hx[2];
            r_hx[2] <= i_x;
            r_hy[0] <= r_hy[1];
            r_hy[1] <= r_hy[2];
            r_hy[2] <= i_y;
        end
    end

endmodule

FILE: hdl/crss_queue.sv
// Small job queue between front end and evaluator, register based.
// Depends on crss_pkg for the job type.
module crss_queue
    import crss_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

FILE: hdl/crss_eval.sv
// Back end: steps through each job's vertices and evaluates the cubic in a
// five-stage pipeline ending in the output register. Depends on crss_pkg.
module crss_eval
    import crss_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  t_job                      i_q_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_x,
    output logic signed [COORD_W-1:0] o_y,
    output logic                      o_move,
    output logic                      o_last
);

    // sequencer
    logic             r_busy;
    t_job             r_job;
    logic [IDX_W-1:0] r_i;
    logic             w_adv, w_cur_last, w_fin;
    t_coef            w_cf [2];

    // pipeline
    logic               r_v1, r_v2, r_v3, r_v4, r_v5;
    logic               r_m1, r_m2, r_m3, r_m4;
    logic               r_l1, r_l2, r_l3, r_l4;
    logic signed [23:0] r_pa [2];
    logic signed [23:0] r_pb [2];
    logic signed [26:0] r_pc [2];
    logic signed [26:0] r_pd [2];
    logic signed [28:0] r_num [2];
    logic [26:0]        r_mag [2];
    logic [1:0]         r_neg3, r_neg4;     // bit per axis
    logic [55:0]        r_prod [2];
    logic signed [COORD_W-1:0] r_out [2];
    logic               r_mv5, r_ls5;

    assign w_adv      = !r_v5 || i_ready;
    assign w_cur_last = r_job.single || (r_i == IDX_W'(SUBDIV));
    assign w_fin      = !r_busy || w_cur_last;
    assign o_pop      = w_adv && w_fin && i_q_valid;
    assign w_cf[0]    = r_job.cx;
    assign w_cf[1]    = r_job.cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_adv) begin
            if (w_fin) begin
                r_busy <= i_q_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_fin) begin
                r_job <= i_q_job;
                r_i   <= IDX_W'(1);
            end else begin
                r_i   <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= r_busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [7:0]  k1, k2, k3;
        logic signed [20:0] q;
        if (w_adv) begin
            k1 = $signed({1'b0, k_lin(r_i)});
            k2 = $signed({1'b0, k_sq(r_i)});
            k3 = $signed({1'b0, k_cub(r_i)});
            r_m1 <= r_job.is_move;
            r_l1 <= w_cur_last;
            r_m2 <= r_m1;
            r_l2 <= r_l1;
            r_m3 <= r_m2;
            r_l3 <= r_l2;
            r_m4 <= r_m3;
            r_l4 <= r_l3;
            r_mv5 <= r_m4;
            r_ls5 <= r_l4;
            r_neg4 <= r_neg3;
            for (int ax = 0; ax < 2; ax++) begin
                // stage 1: weighted terms
                r_pa[ax] <= 24'(w_cf[ax].a) * 24'sd250;
                r_pb[ax] <= 24'(w_cf[ax].b) * 24'(k1);
                r_pc[ax] <= 27'(w_cf[ax].c) * 27'(k2);
                r_pd[ax] <= 27'(w_cf[ax].d) * 27'(k3);
                // stage 2: numerator
                r_num[ax] <= 29'(r_pa[ax]) + 29'(r_pb[ax]) + 29'(r_pc[ax]) + 29'(r_pd[ax]);
                // stage 3: magnitude plus half divisor
                r_neg3[ax] <= r_num[ax][28];
                r_mag[ax]  <= (r_num[ax][28] ? 27'(-r_num[ax]) : 27'(r_num[ax]))
                              + 27'(DEN);
                // stage 4: divide by 250 through reciprocal
                r_prod[ax] <= 56'(r_mag[ax]) * 56'(RECIP);
                // stage 5: sign and saturate
                q = $signed({1'b0, r_prod[ax][RECIP_SHIFT +: 20]});
                if (r_neg4[ax]) begin
                    q = -q;
                end
                if (q > 21'sd32767) begin
                    r_out[ax] <= 16'sh7fff;
                end else if (q < -21'sd32768) begin
                    r_out[ax] <= 16'sh8000;
                end else begin
                    r_out[ax] <= q[15:0];
                end
            end
        end
    end

    assign o_valid = r_v5;
    assign o_x     = r_out[0];
    assign o_y     = r_out[1];
    assign o_move  = r_mv5;
    assign o_last  = r_ls5;

endmodule

FILE: hdl/catmull_rom_stroke_smoother.sv
// Catmull-Rom stroke smoother, top level: front end, job queue, evaluator.
// Throughput: one vertex per cycle from the evaluator while jobs are queued and the output
// is not stalled; a spline point yields SUBDIV vertices, a start or straight point one.
// Reset: synchronous active low; clears stroke state, queue and pipeline valids.
// Depends on crss_pkg, crss_front, crss_queue, crss_eval.
module catmull_rom_stroke_smoother
    import crss_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] x_coord, [31:16] y_coord
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] out_x, [31:16] out_y
    output logic        o_m_tuser,   // [0] is_move
    output logic        o_m_tlast    // last_of_run
);

    logic                      w_full, w_accept, w_push, w_pop, w_q_valid;
    t_job                      w_job, w_q_job;
    logic signed [COORD_W-1:0] w_out_x, w_out_y;

    // no transaction is taken while reset is held
    assign o_s_tready = i_rst_n && !w_full;
    assign w_accept   = i_s_tvalid && o_s_tready;

    crss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_cmd    (i_s_tuser),
        .i_x      ($signed(i_s_tdata[15:0])),
        .i_y      ($signed(i_s_tdata[31:16])),
        .o_push   (w_push),
        .o_job    (w_job)
    );

    crss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    crss_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_x       (w_out_x),
        .o_y       (w_out_y),
        .o_move    (o_m_tuser),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {w_out_y, w_out_x};

    // a job is only produced when the queue has room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    // every start transaction opens a path with a move job
    a_start_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tuser == CMD_START) |-> (w_push && w_job.is_move && w_job.single))
        else $error("start command did not produce a move job");

    // end transactions never produce vertices
    a_end_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tuser == CMD_END) |-> !w_push)
        else $error("end command produced a job");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for catmull_rom_stroke_smoother: drives pen-point
// commands with random gaps and back-pressure and checks every vertex in order.
// Depends on crss_pkg and the catmull_rom_stroke_smoother RTL.
module tb_top;
    import crss_pkg::*;

    localparam logic [1:0] CMD_BAD = 2'd3;    // unused command code, block ignores it
    localparam int STROKE_ITEMS = 410;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               mv;
        logic               last;
    } t_vertex;

    // Tracks stroke state, predicts vertices and compares them in order.
    class stroke_scoreboard;
        bit                 open_stroke;
        logic signed [15:0] hist_x [3];
        logic signed [15:0] hist_y [3];
        int unsigned        seen;
        t_vertex            pending_vertices [$];
        int unsigned        errors;
        int unsigned        checked;
        int unsigned        segments;
        int unsigned        clipped;

        function new();
            open_stroke = 0;
            seen        = 0;
            for (int k = 0; k < 3; k++) begin
                hist_x[k] = '0;
                hist_y[k] = '0;
            end
        endfunction

        function int unsigned pending();
            return pending_vertices.size();
        endfunction

        function void add_vertex(input logic signed [15:0] x, y, input logic mv, last);
            t_vertex v;
            v.x    = x;
            v.y    = y;
            v.mv   = mv;
            v.last = last;
            pending_vertices.insert(pending_vertices.size(), v);
        endfunction

        function void shift_in(input logic signed [15:0] x, y);
            hist_x[0] = hist_x[1];
            hist_x[1] = hist_x[2];
            hist_x[2] = x;
            hist_y[0] = hist_y[1];
            hist_y[1] = hist_y[2];
            hist_y[2] = y;
            if (seen < 3) seen++;
        endfunction

        // one axis of the segment between p1 and p2, step i of SUBDIV
        function logic signed [15:0] curve_axis(input longint p0, p1, p2, p3, input int i);
            longint s;
            longint den;
            longint num;
            longint q;
            s   = SUBDIV;
            den = 2 * s * s * s;
            num = den * p1 + s * s * i * (p2 - p0)
                + s * i * i * (2 * p0 - 5 * p1 + 4 * p2 - p3)
                + i * i * i * (-p0 + 3 * p1 - 3 * p2 + p3);
            if (num >= 0) q = (num + den / 2) / den;
            else          q = -((-num + den / 2) / den);
            if (q > 32767) begin
                q = 32767;
                clipped++;
            end else if (q < -32768) begin
                q = -32768;
                clipped++;
            end
            return q[15:0];
        endfunction

        // returns 1 when the command changed anything
        function bit note_point(input logic [1:0] cmd, input logic signed [15:0] x, y);
            bit took;
            took = 0;
            case (cmd)
                CMD_START: begin
                    open_stroke = 1;
                    seen        = 0;
                    shift_in(x, y);
                    add_vertex(x, y, 1'b1, 1'b1);
                    took = 1;
                end
                CMD_ADD: begin
                    if (open_stroke) begin
                        if (seen < 3) begin
                            add_vertex(x, y, 1'b0, 1'b1);
                        end else begin
                            segments++;
                            for (int i = 1; i <= SUBDIV; i++)
                                add_vertex(curve_axis(hist_x[0], hist_x[1], hist_x[2], x, i),
                                           curve_axis(hist_y[0], hist_y[1], hist_y[2], y, i),
                                           1'b0, i == SUBDIV);
                        end
                        shift_in(x, y);
                        took = 1;
                    end
                end
                CMD_END: begin
                    took        = open_stroke;
                    open_stroke = 0;
                    seen        = 0;
                end
                default: took = 0;
            endcase
            return took;
        endfunction

        task report(input string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_vertex(input logic signed [15:0] x, y, input logic mv, last);
            t_vertex want;
            if (pending_vertices.size() == 0) begin
                report($sformatf("unexpected vertex x=%0d y=%0d", x, y));
                return;
            end
            want = pending_vertices.pop_front();
            if (x !== want.x)
                report($sformatf("vertex %0d x=%0d, want %0d", checked, x, want.x));
            if (y !== want.y)
                report($sformatf("vertex %0d y=%0d, want %0d", checked, y, want.y));
            if (mv !== want.mv)
                report($sformatf("vertex %0d is_move=%0b, want %0b", checked, mv, want.mv));
            if (last !== want.last)
                report($sformatf("vertex %0d last=%0b, want %0b", checked, last, want.last));
            checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;   // [15:0] x_coord, [31:16] y_coord
    logic [1:0]  i_s_tuser;   // [1:0] command
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;   // [15:0] out_x, [31:16] out_y
    logic        o_m_tuser;   // [0] is_move
    logic        o_m_tlast;   // last_of_run

    stroke_scoreboard sb = new();

    bit          src_calm;
    bit          sink_calm;
    int          sink_wait;
    int unsigned sent;
    int unsigned effective;
    logic signed [15:0] pen_x;
    logic signed [15:0] pen_y;

    catmull_rom_stroke_smoother dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mostly no gap or a short one, now and then a long one
    function int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function logic signed [15:0] clamp16(input longint v);
        if (v > 32767)  return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    task send(input logic [1:0] cmd, input logic signed [15:0] x, y);
        int g;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {y, x};
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
        if (sb.note_point(cmd, x, y)) effective++;
        g = pick_gap(src_calm);
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // next pen position: mostly a small step, sometimes a jump or a corner value
    task next_pen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            pen_x = clamp16(longint'(pen_x) + $signed($urandom_range(0, 400)) - 200);
            pen_y = clamp16(longint'(pen_y) + $signed($urandom_range(0, 400)) - 200);
        end else if (r < 90) begin
            pen_x = 16'($urandom());
            pen_y = 16'($urandom());
        end else begin
            pen_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            pen_y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end
    endtask

    // output side: check every vertex, stall at random
    always @(posedge i_clk) begin : sink_side
        int g;
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_vertex(o_m_tdata[15:0], o_m_tdata[31:16], o_m_tuser, o_m_tlast);
        if (sink_wait > 0) begin
            sink_wait  <= sink_wait - 1;
            i_m_tready <= 1'b0;
        end else begin
            g = pick_gap(sink_calm);
            if (g > 0) begin
                sink_wait  <= g - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int n_adds;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= CMD_START;
        i_m_tready <= 1'b0;
        sink_wait  = 0;
        src_calm   = 0;
        sink_calm  = 0;
        sent       = 0;
        effective  = 0;
        pen_x      = '0;
        pen_y      = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: commands that do nothing, extremes, overshoot, restart
        send(CMD_ADD,   16'sd100, 16'sd200);       // no open stroke
        send(CMD_END,   16'sd0,   16'sd0);         // end with nothing open
        send(CMD_BAD,   16'sh7fff, 16'sh8000);
        send(CMD_START, 16'sh8000, 16'sh7fff);
        send(CMD_ADD,   16'sh7fff, 16'sh8000);
        send(CMD_ADD,   16'sh7fff, 16'sh8000);
        send(CMD_ADD,   16'sh8000, 16'sh7fff);     // first spline, overshoots both ways
        send(CMD_ADD,   16'sh8000, 16'sh7fff);
        send(CMD_ADD,   16'sd0,    16'sd0);
        send(CMD_BAD,   16'sd5,    16'sd5);        // ignored mid-stroke
        send(CMD_ADD,   16'sd1,    -16'sd1);
        send(CMD_START, 16'sd0,    16'sd0);        // restart while open
        send(CMD_ADD,   16'sd16,   16'sd16);
        send(CMD_ADD,   16'sd32,   -16'sd32);
        send(CMD_ADD,   -16'sd48,  16'sd48);
        send(CMD_ADD,   16'sd64,   16'sd3);
        send(CMD_END,   16'sh7fff, 16'sh7fff);
        send(CMD_ADD,   16'sd7,    16'sd7);        // after end: ignored
        send(CMD_START, 16'sh7fff, 16'sh7fff);
        send(CMD_ADD,   16'sh8000, 16'sh8000);
        send(CMD_END,   16'sd0,    16'sd0);

        // random strokes, with some noise and broken sequences in between
        while (effective < STROKE_ITEMS) begin
            src_calm  = ($urandom_range(0, 5) == 0);
            sink_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0) begin
                send(2'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()));
            end else begin
                next_pen();
                send(CMD_START, pen_x, pen_y);
                n_adds = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                     : $urandom_range(3, 12);
                for (int k = 0; k < n_adds; k++) begin
                    next_pen();
                    if ($urandom_range(0, 29) == 0)
                        send(CMD_BAD, 16'($urandom()), 16'($urandom()));
                    send(CMD_ADD, pen_x, pen_y);
                end
                // sometimes leave the stroke open so the next start drops it
                if ($urandom_range(0, 5) != 0)
                    send(CMD_END, 16'($urandom()), 16'($urandom()));
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        $display("%0d commands sent, %0d took effect, %0d spline segments", sent, effective,
                 sb.segments);
        $display("%0d vertices checked, %0d coordinates clipped to range", sb.checked,
                 sb.clipped);
        if (sb.errors == 0)
            $display("[catmull_rom_stroke_smoother] OK");
        else
            $display("[catmull_rom_stroke_smoother] ERROR");
        $finish;
    end

    initial begin
        #(8 * 1000000);
        $display("timeout, %0d vertices still pending", sb.pending());
        $display("[catmull_rom_stroke_smoother] ERROR");
        $finish;
    end

endmodule
